### design/tss_pkg.sv
// shared constants, types and config register codes of the track smoother
package tss_pkg;

	localparam int HIST_DEPTH = 32;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int POS_W      = 16;
	localparam int TS_W       = 48;
	localparam int LEN_W      = 7;
	localparam int GAP_W      = 32;
	localparam int JUMP_W     = 16;
	localparam int WGT_W      = 9;
	localparam int MINLEN_W   = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int WORD_W     = TS_W + 2 * POS_W;
	localparam int PROD_W     = WGT_W + POS_W;

	localparam logic [GAP_W-1:0]    GAP_RST    = GAP_W'(400000);
	localparam logic [JUMP_W-1:0]   JUMP_RST   = JUMP_W'(4000);
	localparam logic [WGT_W-1:0]    WGT_RST    = WGT_W'(192);
	localparam logic [WGT_W-1:0]    WGT_FULL   = WGT_W'(256);
	localparam logic [MINLEN_W-1:0] MINLEN_RST = MINLEN_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAP_LIMIT     = 3'd0,
		CFG_JUMP_LIMIT    = 3'd1,
		CFG_SMOOTH_WEIGHT = 3'd2,
		CFG_SMOOTHING_ON  = 3'd3,
		CFG_MIN_TRACK_LEN = 3'd4
	} cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic rd_last;
		logic diff;
		logic square;
		logic decide;
		logic commit;
		logic ro_start;
		logic ro_rd;
		logic ro_load;
		logic ro_mark;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic ro_short;
		logic ro_last;
	} sts_t;

endpackage

### design/tss_det_if.sv
// detection / readout request channel
interface tss_det_if;
	import tss_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [POS_W-1:0]    raw_x;
	logic [POS_W-1:0]    raw_y;
	logic [TS_W-1:0]     sample_us;

	modport source (output valid, req_type, raw_x, raw_y, sample_us, input ready);
	modport sink (input valid, req_type, raw_x, raw_y, sample_us, output ready);
endinterface

### design/tss_res_if.sv
// result channel
interface tss_res_if;
	import tss_pkg::*;

	logic                valid;
	logic                ready;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [TS_W-1:0]     entry_us;
	logic                new_track;
	logic [LEN_W-1:0]    track_len;
	logic                in_progress;
	logic                last_item;
	logic                no_track;

	modport source (output valid, pos_x, pos_y, entry_us, new_track, track_len,
		in_progress, last_item, no_track, input ready);
	modport sink (input valid, pos_x, pos_y, entry_us, new_track, track_len,
		in_progress, last_item, no_track, output ready);
endinterface

### design/tss_ram.sv
// generic single-write, single-read ram with registered read data
module tss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### design/tss_ctrl.sv
// sequencing state machine for detections and history readout
module tss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          det_valid,
	input  logic          det_req_type,
	output logic          det_ready,
	input  tss_pkg::sts_t sts,
	output tss_pkg::cmd_t cmd
);
	import tss_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LAST,
		ST_DIFF,
		ST_SQUARE,
		ST_DECIDE,
		ST_COMMIT,
		ST_RO_CHECK,
		ST_RO_MARK,
		ST_RO_RD,
		ST_RO_LOAD
	} state_t;

	state_t state_q;
	logic   accept;

	assign det_ready = (state_q == ST_IDLE);
	assign accept    = det_valid && det_ready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.rd_last  = (state_q == ST_RD_LAST);
		cmd.diff     = (state_q == ST_DIFF);
		cmd.square   = (state_q == ST_SQUARE);
		cmd.decide   = (state_q == ST_DECIDE);
		cmd.commit   = (state_q == ST_COMMIT) && sts.out_free;
		cmd.ro_start = (state_q == ST_RO_CHECK);
		cmd.ro_rd    = (state_q == ST_RO_RD);
		cmd.ro_load  = (state_q == ST_RO_LOAD) && sts.out_free;
		cmd.ro_mark  = (state_q == ST_RO_MARK) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= det_req_type ? ST_RO_CHECK : ST_RD_LAST;
					end
				end
				ST_RD_LAST: state_q <= ST_DIFF;
				ST_DIFF:    state_q <= ST_SQUARE;
				ST_SQUARE:  state_q <= ST_DECIDE;
				ST_DECIDE:  state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RO_CHECK: state_q <= sts.ro_short ? ST_RO_MARK : ST_RO_RD;
				ST_RO_MARK: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RO_RD: state_q <= ST_RO_LOAD;
				ST_RO_LOAD: begin
					if (sts.out_free) begin
						state_q <= sts.ro_last ? ST_IDLE : ST_RO_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !det_ready)
		else $error("request accepted while another is in work");

	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ro_load && sts.ro_last) |=> det_ready)
		else $error("readout did not return to idle after last entry");

	a_marker_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RO_MARK) |-> sts.ro_short)
		else $error("empty marker for a track long enough to stream");
endmodule

### design/tss_dp.sv
// datapath: config registers, history ram, distance test, blend, output register
module tss_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tss_pkg::POS_W-1:0]      raw_x,
	input  logic [tss_pkg::POS_W-1:0]      raw_y,
	input  logic [tss_pkg::TS_W-1:0]       sample_us,
	input  tss_pkg::cmd_t                  cmd,
	output tss_pkg::sts_t                  sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [tss_pkg::POS_W-1:0]      pos_x,
	output logic [tss_pkg::POS_W-1:0]      pos_y,
	output logic [tss_pkg::TS_W-1:0]       entry_us,
	output logic                          new_track,
	output logic [tss_pkg::LEN_W-1:0]      track_len,
	output logic                          in_progress,
	output logic                          last_item,
	output logic                          no_track
);
	import tss_pkg::*;

	// configuration
	logic [GAP_W-1:0]    gap_q;
	logic [JUMP_W-1:0]   jump_q;
	logic [WGT_W-1:0]    wgt_q;
	logic                smooth_on_q;
	logic [MINLEN_W-1:0] min_len_q;

	// history bookkeeping
	logic [HIST_AW-1:0] head_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   cursor_q;

	// captured request
	logic [POS_W-1:0] rx_q, ry_q;
	logic [TS_W-1:0]  ts_q;

	// pipeline of the detection path
	logic [POS_W-1:0]  lx_s1, ly_s1, dx_s1, dy_s1;
	logic [TS_W:0]     tdiff_s1;
	logic [2*POS_W-1:0] dx2_s2, dy2_s2, jl2_s2;
	logic              gap_s2;
	logic              fresh_s3;
	logic [PROD_W-1:0] pxa_s3, pxb_s3, pya_s3, pyb_s3;

	// ram
	logic [HIST_AW-1:0] raddr, prev_slot, ro_slot;
	logic [WORD_W-1:0]  rdata, wdata;
	logic [POS_W-1:0]   lx, ly;
	logic [TS_W-1:0]    lt;
	logic [CNT_W:0]     oldest, ro_sum;

	logic               out_valid_q;
	logic               empty;
	logic [WGT_W-1:0]   w_eff, w_cmp;
	logic [PROD_W:0]    bsum_x, bsum_y;
	logic [POS_W-1:0]   sx, sy;
	logic [CNT_W-1:0]   count_nx;
	logic [2*POS_W:0]   dist2;

	assign lx = rdata[POS_W-1:0];
	assign ly = rdata[2*POS_W-1:POS_W];
	assign lt = rdata[WORD_W-1:2*POS_W];

	assign empty     = (count_q == '0);
	assign prev_slot = (head_q == '0) ? HIST_AW'(HIST_DEPTH - 1) : head_q - 1'b1;
	assign oldest    = ({1'b0, CNT_W'(head_q)} >= {1'b0, count_q})
		? {1'b0, CNT_W'(head_q)} - {1'b0, count_q}
		: {1'b0, CNT_W'(head_q)} + (CNT_W+1)'(HIST_DEPTH) - {1'b0, count_q};
	assign ro_sum    = oldest + {1'b0, cursor_q};
	assign ro_slot   = (ro_sum >= (CNT_W+1)'(HIST_DEPTH))
		? HIST_AW'(ro_sum - (CNT_W+1)'(HIST_DEPTH)) : HIST_AW'(ro_sum);
	assign raddr     = cmd.rd_last ? prev_slot : ro_slot;

	assign w_eff = (wgt_q > WGT_FULL) ? WGT_FULL : wgt_q;
	assign w_cmp = WGT_FULL - w_eff;

	assign bsum_x = {1'b0, pxa_s3} + {1'b0, pxb_s3};
	assign bsum_y = {1'b0, pya_s3} + {1'b0, pyb_s3};
	assign sx = (!fresh_s3 && smooth_on_q) ? bsum_x[POS_W+7:8] : rx_q;
	assign sy = (!fresh_s3 && smooth_on_q) ? bsum_y[POS_W+7:8] : ry_q;
	assign wdata = {ts_q, sy, sx};

	assign count_nx = fresh_s3 ? CNT_W'(1)
		: ((count_q < CNT_W'(HIST_DEPTH)) ? count_q + 1'b1 : count_q);

	assign dist2 = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.ro_short = empty || (LEN_W'(count_q) < min_len_q);
	assign sts.ro_last  = ((cursor_q + 1'b1) == count_q);
	assign out_valid    = out_valid_q;

	tss_ram #(
		.WIDTH(WORD_W),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (head_q),
		.wdata (wdata),
		.re    (cmd.rd_last || cmd.ro_rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= GAP_RST;
			jump_q      <= JUMP_RST;
			wgt_q       <= WGT_RST;
			smooth_on_q <= 1'b1;
			min_len_q   <= MINLEN_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_GAP_LIMIT:     gap_q       <= cfg_data[GAP_W-1:0];
				CFG_JUMP_LIMIT:    jump_q      <= cfg_data[JUMP_W-1:0];
				CFG_SMOOTH_WEIGHT: wgt_q       <= cfg_data[WGT_W-1:0];
				CFG_SMOOTHING_ON:  smooth_on_q <= cfg_data[0];
				CFG_MIN_TRACK_LEN: min_len_q   <= cfg_data[MINLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				head_q  <= (head_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_nx;
			end
			if (cmd.ro_start) begin
				cursor_q <= '0;
			end else if (cmd.ro_load) begin
				cursor_q <= sts.ro_last ? '0 : cursor_q + 1'b1;
			end
			if (cmd.commit || cmd.ro_load || cmd.ro_mark) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rx_q <= raw_x;
			ry_q <= raw_y;
			ts_q <= sample_us;
		end
		if (cmd.diff) begin
			lx_s1    <= lx;
			ly_s1    <= ly;
			dx_s1    <= (rx_q >= lx) ? rx_q - lx : lx - rx_q;
			dy_s1    <= (ry_q >= ly) ? ry_q - ly : ly - ry_q;
			tdiff_s1 <= {1'b0, ts_q} - {1'b0, lt};
		end
		if (cmd.square) begin
			dx2_s2 <= {{POS_W{1'b0}}, dx_s1} * {{POS_W{1'b0}}, dx_s1};
			dy2_s2 <= {{POS_W{1'b0}}, dy_s1} * {{POS_W{1'b0}}, dy_s1};
			jl2_s2 <= {{POS_W{1'b0}}, jump_q} * {{POS_W{1'b0}}, jump_q};
			// backwards time gives a negative difference and never a gap
			gap_s2 <= !tdiff_s1[TS_W] && (tdiff_s1[TS_W-1:0] > TS_W'(gap_q));
		end
		if (cmd.decide) begin
			fresh_s3 <= empty || gap_s2 || (dist2 > {1'b0, jl2_s2});
			pxa_s3   <= PROD_W'(w_eff) * PROD_W'(rx_q);
			pxb_s3   <= PROD_W'(w_cmp) * PROD_W'(lx_s1);
			pya_s3   <= PROD_W'(w_eff) * PROD_W'(ry_q);
			pyb_s3   <= PROD_W'(w_cmp) * PROD_W'(ly_s1);
		end
		if (cmd.commit) begin
			pos_x       <= sx;
			pos_y       <= sy;
			entry_us    <= ts_q;
			new_track   <= fresh_s3;
			track_len   <= LEN_W'(count_nx);
			in_progress <= (LEN_W'(count_nx) >= min_len_q);
			last_item   <= 1'b1;
			no_track    <= 1'b0;
		end else if (cmd.ro_load) begin
			pos_x       <= lx;
			pos_y       <= ly;
			entry_us    <= lt;
			new_track   <= 1'b0;
			track_len   <= LEN_W'(count_q);
			in_progress <= 1'b1;
			last_item   <= sts.ro_last;
			no_track    <= 1'b0;
		end else if (cmd.ro_mark) begin
			pos_x       <= '0;
			pos_y       <= '0;
			entry_us    <= '0;
			new_track   <= 1'b0;
			track_len   <= LEN_W'(count_q);
			in_progress <= 1'b0;
			last_item   <= 1'b1;
			no_track    <= 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HIST_DEPTH))
		else $error("history count beyond depth");

	a_commit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (count_q != '0) && out_valid_q)
		else $error("detection stored without a held entry and result");

	a_stream_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ro_rd || cmd.ro_load) |-> !empty)
		else $error("history streamed while empty");
endmodule

### design/track_segmenting_smoother.sv
// Track history with jump/gap segmentation and moving-average smoothing.
// Channels: det carries requests (req_type 0 = detection with raw_x, raw_y,
// sample_us; req_type 1 = history readout), res carries results; both
// move a request when valid and ready are high at a rising clk edge.
// The config port writes register cfg_idx with cfg_data when cfg_we is high:
// 0 gap_limit_us, 1 jump_limit, 2 smooth_weight, 3 smoothing_on,
// 4 min_track_len; write only while no request is in work.
// One request is worked at a time; det.ready is high only when idle.
// A detection reads the newest entry from the history ram, then runs a
// difference stage, a squaring stage and a decision/blend stage: its one
// result is registered in the commit step, and no new request is taken
// until the previous detection has committed its result.
// A readout streams the history oldest first, one ram read and one load per
// entry, or gives one marker result with no_track set.
// last_item marks the final result of each request.
// A result sits in the output register until res.ready; a stall holds the
// controller at its commit, marker or load step, and a new request may be
// accepted while the last result of the previous one still waits.
// Reset empties the history, drops any waiting result and loads the register
// defaults; the ram needs no clearing since entries are only used after a write.
module track_segmenting_smoother (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tss_pkg::CFG_DATA_W-1:0] cfg_data,
	tss_det_if.sink                        det,
	tss_res_if.source                      res
);
	import tss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.det_valid    (det.valid),
		.det_req_type (det.req_type),
		.det_ready    (det.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	tss_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.raw_x       (det.raw_x),
		.raw_y       (det.raw_y),
		.sample_us   (det.sample_us),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (res.ready),
		.out_valid   (res.valid),
		.pos_x       (res.pos_x),
		.pos_y       (res.pos_y),
		.entry_us    (res.entry_us),
		.new_track   (res.new_track),
		.track_len   (res.track_len),
		.in_progress (res.in_progress),
		.last_item   (res.last_item),
		.no_track    (res.no_track)
	);
endmodule

### test/tss_tb_pkg.sv
// request kinds and request record shared by the track smoother testbench files
package tss_tb_pkg;
	import tss_pkg::*;

	typedef enum logic {
		REQ_DETECT  = 1'b0,
		REQ_READOUT = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t        kind;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [TS_W-1:0]  us;
	} track_req_t;

endpackage

### test/track_segmenting_smoother_checker.sv
// watches the track smoother channels, predicts each result and compares
module track_segmenting_smoother_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tss_pkg::CFG_DATA_W-1:0] cfg_data,
	tss_det_if                             det,
	tss_res_if                             res,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tss_pkg::*;
	import tss_tb_pkg::*;

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [TS_W-1:0]  entry_us;
		logic             new_track;
		logic [LEN_W-1:0] track_len;
		logic             in_progress;
		logic             last_item;
		logic             no_track;
	} track_result_t;

	track_result_t expected_results[$];

	logic [2*POS_W-1:0] point_mem [HIST_DEPTH];
	logic [TS_W-1:0]    stamp_mem [HIST_DEPTH];
	int unsigned        head_slot;
	int unsigned        held;

	logic [GAP_W-1:0]    gap_lim;
	logic [JUMP_W-1:0]   jump_lim;
	logic [WGT_W-1:0]    weight;
	logic                smooth_en;
	logic [MINLEN_W-1:0] min_len;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input longint unsigned got,
		input longint unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic queue_result(input track_result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic predict_request(input req_kind_t kind, input logic [POS_W-1:0] rx,
		input logic [POS_W-1:0] ry, input logic [TS_W-1:0] us);
		int unsigned newest, oldest, slot, w;
		logic [POS_W-1:0] lx, ly, sx, sy;
		logic [TS_W-1:0] lt;
		longint unsigned dx, dy, lim;
		logic fresh;
		track_result_t r;
		if (kind == REQ_DETECT) begin
			sx = rx;
			sy = ry;
			fresh = 1'b1;
			if (held != 0) begin
				newest = (head_slot + HIST_DEPTH - 1) % HIST_DEPTH;
				lx = point_mem[newest][POS_W-1:0];
				ly = point_mem[newest][2*POS_W-1:POS_W];
				lt = stamp_mem[newest];
				dx = (rx >= lx) ? rx - lx : lx - rx;
				dy = (ry >= ly) ? ry - ly : ly - ry;
				lim = jump_lim;
				// a timestamp going backwards never counts as a gap
				fresh = ((us > lt) && (us - lt > TS_W'(gap_lim))) ||
					(dx * dx + dy * dy > lim * lim);
				if (!fresh && smooth_en) begin
					w = (weight > WGT_FULL) ? 256 : weight;
					sx = POS_W'((w * rx + (256 - w) * lx) >> 8);
					sy = POS_W'((w * ry + (256 - w) * ly) >> 8);
				end
			end
			if (fresh)
				held = 0;
			point_mem[head_slot] = {sy, sx};
			stamp_mem[head_slot] = us;
			head_slot = (head_slot + 1) % HIST_DEPTH;
			if (held < HIST_DEPTH)
				held++;
			r = '{sx, sy, us, fresh, LEN_W'(held), held >= min_len, 1'b1, 1'b0};
			queue_result(r);
		end else if (held < min_len || held == 0) begin
			r = '{'0, '0, '0, 1'b0, LEN_W'(held), 1'b0, 1'b1, 1'b1};
			queue_result(r);
		end else begin
			oldest = (head_slot + HIST_DEPTH - held) % HIST_DEPTH;
			for (int unsigned i = 0; i < held; i++) begin
				slot = (oldest + i) % HIST_DEPTH;
				r = '{point_mem[slot][POS_W-1:0], point_mem[slot][2*POS_W-1:POS_W],
					stamp_mem[slot], 1'b0, LEN_W'(held), 1'b1, i == held - 1, 1'b0};
				queue_result(r);
			end
		end
	endtask

	task automatic check_result();
		track_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending: x=%0h y=%0h us=%0h len=%0d",
				res.pos_x, res.pos_y, res.entry_us, res.track_len));
			return;
		end
		want = expected_results[0];
		expected_results.delete(0);
		check_field("pos_x", res.pos_x, want.pos_x);
		check_field("pos_y", res.pos_y, want.pos_y);
		check_field("entry_us", res.entry_us, want.entry_us);
		check_field("new_track", res.new_track, want.new_track);
		check_field("track_len", res.track_len, want.track_len);
		check_field("in_progress", res.in_progress, want.in_progress);
		check_field("last_item", res.last_item, want.last_item);
		check_field("no_track", res.no_track, want.no_track);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_lim = GAP_RST;
			jump_lim = JUMP_RST;
			weight = WGT_RST;
			smooth_en = 1'b1;
			min_len = MINLEN_RST;
			head_slot = 0;
			held = 0;
			expected_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (res.valid && res.ready)
				check_result();
			if (det.valid && det.ready)
				predict_request(req_kind_t'(det.req_type), det.raw_x, det.raw_y, det.sample_us);
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_GAP_LIMIT:     gap_lim = cfg_data[GAP_W-1:0];
					CFG_JUMP_LIMIT:    jump_lim = cfg_data[JUMP_W-1:0];
					CFG_SMOOTH_WEIGHT: weight = cfg_data[WGT_W-1:0];
					CFG_SMOOTHING_ON:  smooth_en = cfg_data[0];
					CFG_MIN_TRACK_LEN: min_len = cfg_data[MINLEN_W-1:0];
					default: ;
				endcase
			end
			pending = expected_results.size();
		end
	end

endmodule

### test/track_segmenting_smoother_tb.sv
// stimulus, handshake pacing and verdict for the track segmenting smoother
module track_segmenting_smoother_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tss_pkg::*;
	import tss_tb_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int RESET_LEN   = 8;
	localparam int SEGMENTS    = 6;
	localparam int PER_SEG     = 51;
	localparam int SETTLE      = 20;
	localparam int HOLD_AT     = 313;
	localparam int HOLD_CYCLES = 300;

	// register settings per random segment
	localparam logic [GAP_W-1:0]    GAP_SET  [SEGMENTS] =
		'{400000, 32'hFFFF_FFFF, 1000000, 32'hFFFF_FFFF, 0, 50000};
	localparam logic [JUMP_W-1:0]   JUMP_SET [SEGMENTS] = '{4000, 65535, 8000, 65535, 0, 2000};
	localparam logic [WGT_W-1:0]    WGT_SET  [SEGMENTS] = '{192, 300, 0, 511, 256, 128};
	localparam logic                ON_SET   [SEGMENTS] = '{1, 1, 1, 0, 1, 1};
	localparam logic [MINLEN_W-1:0] MIN_SET  [SEGMENTS] = '{4, 1, 0, 64, 127, 2};
	localparam int                  BREAK_SET[SEGMENTS] = '{6, 1, 6, 1, 6, 3};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;

	int                send_idle;
	int                recv_idle;
	int                break_odds;
	logic [POS_W-1:0]  cur_x;
	logic [POS_W-1:0]  cur_y;
	logic [TS_W-1:0]   cur_us;
	logic [GAP_W-1:0]  cur_gap;

	tss_det_if det();
	tss_res_if res();

	track_segmenting_smoother DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.det      (det),
		.res      (res)
	);

	track_segmenting_smoother_checker history_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.det      (det),
		.res      (res),
		.errors   (errors),
		.pending  (pending)
	);

	always #CLK_HALF clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// result side: random stalls plus one long hold-off late in the run
	initial begin
		int det_seen;
		int hold_left;
		bit hold_done;
		det_seen = 0;
		hold_left = 0;
		hold_done = 1'b0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (det.valid && det.ready)
				det_seen++;
			if (!hold_done && det_seen >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic apply_config(input logic [GAP_W-1:0] gap, input logic [JUMP_W-1:0] jump,
		input logic [WGT_W-1:0] wgt, input logic smooth, input logic [MINLEN_W-1:0] min_len);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_GAP_LIMIT;
		cfg_data <= CFG_DATA_W'(gap);
		@(posedge clk);
		cfg_idx <= CFG_JUMP_LIMIT;
		cfg_data <= CFG_DATA_W'(jump);
		@(posedge clk);
		cfg_idx <= CFG_SMOOTH_WEIGHT;
		cfg_data <= CFG_DATA_W'(wgt);
		@(posedge clk);
		cfg_idx <= CFG_SMOOTHING_ON;
		cfg_data <= CFG_DATA_W'(smooth);
		@(posedge clk);
		cfg_idx <= CFG_MIN_TRACK_LEN;
		cfg_data <= CFG_DATA_W'(min_len);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_gap = gap;
	endtask

	// returns at the edge where the request was taken
	task automatic send_request(input track_req_t r);
		while ($urandom_range(99) < send_idle) begin
			det.valid <= 1'b0;
			@(posedge clk);
		end
		det.valid <= 1'b1;
		det.req_type <= r.kind;
		det.raw_x <= r.x;
		det.raw_y <= r.y;
		det.sample_us <= r.us;
		do
			@(posedge clk);
		while (!det.ready);
	endtask

	task automatic detect(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
		input logic [TS_W-1:0] us);
		send_request('{REQ_DETECT, x, y, us});
	endtask

	// position and time of a readout are don't-care, so they carry junk
	task automatic readout();
		send_request('{REQ_READOUT, POS_W'($urandom), POS_W'($urandom),
			TS_W'({$urandom, $urandom})});
	endtask

	task automatic wait_drained();
		det.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly a continuing track with small steps, some breaks, junk and readouts
	task automatic random_request();
		track_req_t r;
		int roll;
		roll = $urandom_range(99);
		r.kind = REQ_DETECT;
		r.x = cur_x + POS_W'($urandom_range(400)) - POS_W'(200);
		r.y = cur_y + POS_W'($urandom_range(400)) - POS_W'(200);
		r.us = cur_us + TS_W'($urandom_range(30000));
		if (roll < 14) begin
			r.kind = REQ_READOUT;
			r.x = POS_W'($urandom);
			r.y = POS_W'($urandom);
			r.us = TS_W'({$urandom, $urandom});
		end else if (roll < 14 + break_odds) begin
			r.x = POS_W'($urandom);
			r.y = POS_W'($urandom);
			r.us = TS_W'({$urandom, $urandom});
		end else if (roll < 14 + 2 * break_odds) begin
			r.us = cur_us + TS_W'(cur_gap) + TS_W'($urandom_range(1, 1000));
		end else if (roll < 19 + 2 * break_odds) begin
			r.us = cur_us - TS_W'($urandom_range(1, 5000));
		end
		if (r.kind == REQ_DETECT) begin
			cur_x = r.x;
			cur_y = r.y;
			cur_us = r.us;
		end
		send_request(r);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_GAP_LIMIT;
		cfg_data <= '0;
		det.valid <= 1'b0;
		det.req_type <= REQ_DETECT;
		det.raw_x <= '0;
		det.raw_y <= '0;
		det.sample_us <= '0;
		send_idle = 32;
		recv_idle = 46;
		break_odds = 6;
		cur_x = '0;
		cur_y = '0;
		cur_us = '0;
		cur_gap = GAP_RST;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty history, first point, time going back, gap and
		// jump exactly at the limit, extreme coordinates and timestamps
		readout();
		detect(16'd0, 16'd0, 48'd0);
		detect(16'd16, 16'd32, 48'd100);
		detect(16'd40, 16'd8, 48'd50);
		readout();
		detect(16'd0, 16'd0, 48'd400050);
		readout();
		detect(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		detect(16'hFFFF - 16'd4000, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		detect(16'd60135, 16'd62335, 48'hFFFF_FFFF_FFFF);
		detect(16'd1000, 16'd1000, 48'd1000000);
		detect(16'd1000, 16'd1000, 48'd0);
		detect(16'd1000, 16'd1000, 48'd400001);

		// raw storage, always in progress
		wait_drained();
		apply_config(GAP_RST, JUMP_RST, 9'd511, 1'b0, 7'd0);
		detect(16'd1010, 16'd1000, 48'd400010);
		readout();

		// weight above full scale, minimum beyond the history depth
		wait_drained();
		apply_config(GAP_RST, JUMP_RST, 9'd511, 1'b1, 7'd64);
		detect(16'd1020, 16'd1020, 48'd400020);
		readout();

		// zero weight keeps the previous point
		wait_drained();
		apply_config(GAP_RST, JUMP_RST, 9'd0, 1'b1, 7'd1);
		detect(16'd2000, 16'd1000, 48'd400030);
		readout();

		// zero limits: only an identical point at the same or an earlier time continues
		wait_drained();
		apply_config(32'd0, 16'd0, WGT_RST, 1'b1, 7'd1);
		detect(16'd1020, 16'd1020, 48'd400030);
		detect(16'd1020, 16'd1020, 48'd400031);
		detect(16'd1021, 16'd1020, 48'd400031);
		readout();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_drained();
			send_idle = (seg < 2) ? 32 : (seg < 4) ? 46 : 0;
			recv_idle = (seg < 2) ? 46 : (seg < 4) ? 32 : 0;
			break_odds = BREAK_SET[seg];
			apply_config(GAP_SET[seg], JUMP_SET[seg], WGT_SET[seg], ON_SET[seg], MIN_SET[seg]);
			repeat (PER_SEG) random_request();
		end

		wait_drained();
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
design/tss_pkg.sv
design/tss_det_if.sv
design/tss_res_if.sv
design/tss_ram.sv
design/tss_ctrl.sv
design/tss_dp.sv
design/track_segmenting_smoother.sv
test/tss_tb_pkg.sv
test/track_segmenting_smoother_checker.sv
test/track_segmenting_smoother_tb.sv
